[rtl/pixel_grid_linear_fader_unit_macros.svh]
// Assertion macros for the grid fader.
`ifndef PIXEL_GRID_LINEAR_FADER_UNIT_MACROS_SVH
`define PIXEL_GRID_LINEAR_FADER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PGLF_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PGLF_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PGLF_ASSERT_IMP(label, clk, rst_n, a, b)
`define PGLF_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/pglf_pkg.sv]
// ----------------------------------------------------------------------------
// pglf_pkg
// Types and constants shared by the grid fader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pglf_pkg;
    localparam int unsigned MAX_WIDTH_DEF  = 8;
    localparam int unsigned MAX_HEIGHT_DEF = 8;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned CFG_W   = 4;

    localparam logic       CMD_SET  = 1'b0;
    localparam logic       CMD_TICK = 1'b1;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_RD,
        ST_EVAL,
        ST_DIV,
        ST_WR,
        ST_OUT,
        ST_NEXT,
        ST_EMPTY
    } state_t;
endpackage

[rtl/pixel_grid_linear_fader_unit.sv]
// Flow: a set item passes ST_SET_RD and ST_SET_WR; a tick takes each pixel through ST_RD,
// ST_EVAL and ST_NEXT, adds ST_WR and ST_OUT for a pixel that jumps to its target or fades
// (after three 24-bit restoring divisions in one shared divider) and closes in ST_EMPTY, plus
// any wait on the output register. One item at a time; the divider sets the tick length.
// Each result leaves one written pixel late so that the last one of a tick can carry show.
// Reset: asynchronous active low; grid 8x8, stores read as zero through valid bits.
// ----------------------------------------------------------------------------
// pixel_grid_linear_fader_unit
// Per-pixel RGB crossfade engine for a serpentine LED grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pixel_grid_linear_fader_unit_macros.svh"
module pixel_grid_linear_fader_unit #(
    parameter int unsigned MAX_WIDTH  = pglf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = pglf_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [pglf_pkg::CFG_W-1:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[0], x[3:1], y[6:4], color[30:7], duration_ms[46:31], delta_ms[62:47], pad
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_valid[0], pixel_index[6:1], pixel_color[30:7], pad
    output logic [31:0] m_tdata,
    // show
    output logic        m_tuser
);
    import pglf_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned ENT_W = 2 * COLOR_W + 2 * TIME_W;
    localparam int unsigned NUM_W = TIME_W + 8;

    // entry: {start, target, duration, elapsed}, shown color in its own memory
    logic [ENT_W-1:0]   ent_mem [DEPTH];
    logic [COLOR_W-1:0] shown_mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;

    state_t state_reg, state_next;
    logic [CFG_W-1:0] gw_reg, gh_reg;
    logic [3:0] w_eff, h_eff;
    logic [2:0] xi_reg, yi_reg;
    logic [2:0] cx, cy;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_calc;
    logic [AW-1:0] rd_addr;
    logic [COLOR_W-1:0] col_reg;
    logic [TIME_W-1:0] dur_reg, delta_reg;
    logic [ENT_W-1:0] rd_ent_reg;
    logic [COLOR_W-1:0] rd_shown_reg;
    logic rd_vld_reg;
    logic [COLOR_W-1:0] s_c, t_c;
    logic [TIME_W-1:0] d_c, e_c;
    logic [TIME_W-1:0] e_new_reg;
    logic [COLOR_W-1:0] newc_reg;
    logic any_reg;
    logic [COLOR_W+AW-1:0] hold_d_reg;
    logic [1:0] ch_reg;
    logic [4:0] bit_reg;
    logic [4:0] qcnt_reg;
    logic [NUM_W-1:0] num_reg, rem_reg;
    logic [7:0] quo_reg;
    logic [NUM_W-1:0] prod_s, prod_t;
    logic [NUM_W:0] trial, dvs;
    logic q_bit;
    logic out_v_reg;
    logic [31:0] out_d_reg;
    logic out_show_reg;
    logic out_free;
    logic last_px;
    logic do_write;

    always_comb
    begin
        w_eff = (gw_reg == '0) ? 4'd1 : (gw_reg > 4'(MAX_WIDTH)) ? 4'(MAX_WIDTH) : gw_reg;
        h_eff = (gh_reg == '0) ? 4'd1 : (gh_reg > 4'(MAX_HEIGHT)) ? 4'(MAX_HEIGHT) : gh_reg;
    end

    // strip index of (cx, cy) under the rotated serpentine
    logic [3:0] mx, my;
    logic [7:0] base;
    always_comb
    begin
        mx = w_eff - 4'd1 - {1'b0, cx};
        my = h_eff - 4'd1 - {1'b0, cy};
        base = h_eff * mx;
        if (mx[0])
            addr_calc = AW'(base + 8'(h_eff - 4'd1 - my));
        else
            addr_calc = AW'(base + 8'(my));
    end

    // read the next pixel straight from its computed address
    assign rd_addr = (state_reg == ST_RD) ? addr_calc : addr_reg;

    assign {s_c, t_c, d_c, e_c} = rd_vld_reg ? rd_ent_reg : '0;
    assign last_px = (yi_reg == 3'(h_eff - 4'd1)) && (xi_reg == 3'(w_eff - 4'd1));
    assign out_free = !out_v_reg || m_tready;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            cx = s_tdata[3:1];
            cy = s_tdata[6:4];
        end
        else
        begin
            cx = xi_reg;
            cy = yi_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    if (s_tdata[0] == CMD_TICK)
                        state_next = ST_RD;
                    else if ({1'b0, s_tdata[3:1]} < w_eff && {1'b0, s_tdata[6:4]} < h_eff)
                        state_next = ST_SET_RD;
                end
            ST_SET_RD: state_next = ST_SET_WR;
            ST_SET_WR: state_next = ST_IDLE;
            ST_RD:     state_next = ST_EVAL;
            ST_EVAL:
                if (e_c < d_c)
                    state_next = ST_DIV;
                else if (d_c == '0 && e_c == '0)
                    state_next = ST_WR;
                else
                    state_next = ST_NEXT;
            ST_DIV:
                if (ch_reg == 2'd2 && bit_reg != 5'd8 && qcnt_reg == 5'd1)
                    state_next = ST_WR;
            ST_WR:     state_next = ST_OUT;
            ST_OUT:
                if (!any_reg || out_free)
                    state_next = ST_NEXT;
            ST_NEXT:
                if (last_px)
                    state_next = ST_EMPTY;
                else
                    state_next = ST_RD;
            ST_EMPTY:
                if (out_free)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        do_write = (state_reg == ST_WR);
    end

    assign prod_s = NUM_W'(s_c[23 - 8*ch_reg -: 8]) * NUM_W'(d_c - e_new_reg);
    assign prod_t = NUM_W'(t_c[23 - 8*ch_reg -: 8]) * NUM_W'(e_new_reg);

    // one restoring quotient bit
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign dvs = {9'd0, d_c};
    assign q_bit = (trial >= dvs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gw_reg <= CFG_W'(8);
            gh_reg <= CFG_W'(8);
            vld_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                    gw_reg <= cfg_data;
                else
                    gh_reg <= cfg_data;
            end
            if (state_reg == ST_SET_WR || do_write)
                vld_reg[addr_reg] <= 1'b1;
            if (((state_reg == ST_OUT && any_reg) || state_reg == ST_EMPTY) && out_free)
                out_v_reg <= 1'b1;
            else if (out_v_reg && m_tready)
                out_v_reg <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        rd_ent_reg <= ent_mem[rd_addr];
        rd_shown_reg <= shown_mem[rd_addr];
        rd_vld_reg <= vld_reg[rd_addr];
        if (state_reg == ST_SET_WR)
            ent_mem[addr_reg] <= {(rd_vld_reg ? rd_shown_reg : COLOR_W'(0)), col_reg,
                                  dur_reg, TIME_W'(0)};
        if (do_write)
        begin
            ent_mem[addr_reg] <= {s_c, t_c, d_c, e_new_reg};
            shown_mem[addr_reg] <= newc_reg;
        end
        if (state_reg == ST_SET_WR && !rd_vld_reg)
            shown_mem[addr_reg] <= '0;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                addr_reg <= addr_calc;
                col_reg <= s_tdata[30:7];
                dur_reg <= s_tdata[46:31];
                delta_reg <= s_tdata[62:47];
                xi_reg <= '0;
                yi_reg <= '0;
                any_reg <= 1'b0;
            end
            ST_RD:
                addr_reg <= addr_calc;
            ST_EVAL:
            begin
                if (e_c < d_c)
                begin
                    // clamp elapsed + delta at the duration
                    if ({1'b0, e_c} + {1'b0, delta_reg} > {1'b0, d_c})
                        e_new_reg <= d_c;
                    else
                        e_new_reg <= e_c + delta_reg;
                end
                else
                begin
                    e_new_reg <= TIME_W'(1);
                    newc_reg <= t_c;
                end
                ch_reg <= 2'd0;
                bit_reg <= 5'd8;
            end
            ST_DIV:
            begin
                // load numerator, then one restoring quotient bit a cycle
                if (bit_reg == 5'd8)
                begin
                    num_reg <= prod_s + prod_t;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    qcnt_reg <= 5'(NUM_W);
                    bit_reg <= 5'd7;
                end
                else
                begin
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    rem_reg <= q_bit ? NUM_W'(trial - dvs) : NUM_W'(trial);
                    quo_reg <= {quo_reg[6:0], q_bit};
                    qcnt_reg <= qcnt_reg - 5'd1;
                    if (qcnt_reg == 5'd1)
                    begin
                        newc_reg[23 - 8*ch_reg -: 8] <= {quo_reg[6:0], q_bit};
                        if (ch_reg != 2'd2)
                            ch_reg <= ch_reg + 2'd1;
                        bit_reg <= 5'd8;
                    end
                end
            end
            ST_NEXT:
            begin
                if ({1'b0, xi_reg} == w_eff - 4'd1)
                begin
                    xi_reg <= '0;
                    yi_reg <= yi_reg + 3'd1;
                end
                else
                    xi_reg <= xi_reg + 3'd1;
            end
            default: ;
        endcase
        // send the held pixel on, hold the new one until the next write or the end
        if (state_reg == ST_OUT && any_reg && out_free)
        begin
            out_d_reg <= {1'b0, hold_d_reg, 1'b1};
            out_show_reg <= 1'b0;
        end
        if (state_reg == ST_OUT && (!any_reg || out_free))
        begin
            hold_d_reg <= {newc_reg, addr_reg};
            any_reg <= 1'b1;
        end
        if (state_reg == ST_EMPTY && out_free)
        begin
            out_d_reg <= any_reg ? {1'b0, hold_d_reg, 1'b1} : '0;
            out_show_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_d_reg;
    assign m_tuser = out_show_reg;

    `PGLF_ASSERT_IMP(a_ready_idle, clk, rst_n, s_tready, state_reg == ST_IDLE)
    `PGLF_ASSERT_NEXT(a_set_wr, clk, rst_n, state_reg == ST_SET_RD, state_reg == ST_SET_WR)
    `PGLF_ASSERT_IMP(a_no_div_idle, clk, rst_n, state_reg == ST_DIV, !s_tready)
endmodule
